/* rtl/sds_pkg.sv */
package sds_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DUTY_W = 10;
    localparam int TIMER_W    = 16;
    localparam int REDO_W     = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LATCHING_MODE    = 3'd0,
        REG_INVERT_REQUEST   = 3'd1,
        REG_BRAKE_HIGH       = 3'd2,
        REG_ENERGISE_MS      = 3'd3,
        REG_ENERGISE_DUTY    = 3'd4,
        REG_HOLD_DUTY        = 3'd5,
        REG_REDO_COUNT       = 3'd6,
        REG_REDO_INTERVAL_MS = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        CMD_REQUEST = 1'b0,
        CMD_TICK    = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_ENERGISE = 3'd1,
        PH_HOLD     = 3'd2,
        PH_PULSE    = 3'd3,
        PH_GAP      = 3'd4,
        PH_REST     = 3'd5
    } phase_t;

    typedef struct packed {
        logic                  latching_mode;
        logic                  invert_request;
        logic                  brake_high;
        logic [TIMER_W-1:0]    energise_ms;
        logic [CFG_DUTY_W-1:0] energise_duty;
        logic [CFG_DUTY_W-1:0] hold_duty;
        logic [REDO_W-1:0]     redo_count;
        logic [TIMER_W-1:0]    redo_interval_ms;
    } cfg_t;

endpackage

/* rtl/sds_cfg_regs.sv */
module sds_cfg_regs
    import sds_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.latching_mode    <= 1'b0;
            cfg_reg.invert_request   <= 1'b0;
            cfg_reg.brake_high       <= 1'b0;
            cfg_reg.energise_ms      <= 16'd100;
            cfg_reg.energise_duty    <= 10'd1023;
            cfg_reg.hold_duty        <= 10'd512;
            cfg_reg.redo_count       <= 8'd0;
            cfg_reg.redo_interval_ms <= 16'd100;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                REG_LATCHING_MODE:    cfg_reg.latching_mode    <= cfg_wdata[0];
                REG_INVERT_REQUEST:   cfg_reg.invert_request   <= cfg_wdata[0];
                REG_BRAKE_HIGH:       cfg_reg.brake_high       <= cfg_wdata[0];
                REG_ENERGISE_MS:      cfg_reg.energise_ms      <= cfg_wdata[TIMER_W-1:0];
                REG_ENERGISE_DUTY:    cfg_reg.energise_duty    <= cfg_wdata[CFG_DUTY_W-1:0];
                REG_HOLD_DUTY:        cfg_reg.hold_duty        <= cfg_wdata[CFG_DUTY_W-1:0];
                REG_REDO_COUNT:       cfg_reg.redo_count       <= cfg_wdata[REDO_W-1:0];
                REG_REDO_INTERVAL_MS: cfg_reg.redo_interval_ms <= cfg_wdata[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/sds_seq.sv */
module sds_seq
    import sds_pkg::*;
#(
    parameter int HAS_ENABLE    = 1,
    parameter int DUTY_BITS     = 10,
    parameter int REST_DELAY_MS = 1000
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    input  logic                 in_cmd,
    input  logic                 in_state_req,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [DUTY_BITS-1:0] duty,
    output logic                 brake,
    output logic                 enable,
    output logic                 switch_state
);

    localparam int WIDE_W = DUTY_BITS + CFG_DUTY_W;
    localparam logic [DUTY_BITS-1:0] DUTY_FULL = {DUTY_BITS{1'b1}};

    phase_t               phase_reg, phase_next;
    logic [TIMER_W-1:0]   timer_reg, timer_next;
    logic [REDO_W-1:0]    redo_reg, redo_next;
    logic                 req_reg, req_next;
    logic [DUTY_BITS-1:0] duty_reg, duty_next;
    logic                 brake_reg, brake_next;
    logic                 enable_reg, enable_next;
    logic                 out_valid_reg;

    logic                 adv, is_req, is_tick, active, fire, drive, gap_drive;
    logic [WIDE_W-1:0]    ener_wide, hold_wide;
    logic [DUTY_BITS-1:0] ener_duty, hold_duty, ener_mir, hold_mir;
    logic [DUTY_BITS-1:0] lvl_bh, lvl_nbh;
    logic                 en_on;

    assign in_ready = !out_valid_reg || out_ready;
    assign adv      = in_valid && in_ready;
    assign is_req   = adv && (cmd_t'(in_cmd) == CMD_REQUEST);
    assign is_tick  = adv && (cmd_t'(in_cmd) == CMD_TICK);
    assign active   = (phase_reg != PH_IDLE) && (phase_reg != PH_HOLD);
    assign fire     = is_tick && active && (timer_reg[TIMER_W-1:1] == '0);
    assign drive    = in_state_req ^ cfg.invert_request;
    assign gap_drive = req_reg ^ cfg.invert_request;

    assign ener_wide = {{DUTY_BITS{1'b0}}, cfg.energise_duty};
    assign hold_wide = {{DUTY_BITS{1'b0}}, cfg.hold_duty};
    assign ener_duty = ener_wide[DUTY_BITS-1:0];
    assign hold_duty = hold_wide[DUTY_BITS-1:0];
    assign ener_mir  = cfg.brake_high ? (DUTY_FULL - ener_duty) : ener_duty;
    assign hold_mir  = cfg.brake_high ? (DUTY_FULL - hold_duty) : hold_duty;
    assign lvl_bh    = {DUTY_BITS{cfg.brake_high}};
    assign lvl_nbh   = {DUTY_BITS{!cfg.brake_high}};
    assign en_on     = (HAS_ENABLE != 0);

    // phase, timer, redo count, request
    always_comb begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        redo_next  = redo_reg;
        req_next   = req_reg;
        if (is_req) begin
            req_next = in_state_req;
            if (cfg.latching_mode) begin
                phase_next = PH_PULSE;
                timer_next = cfg.energise_ms;
            end else if (drive) begin
                phase_next = PH_ENERGISE;
                timer_next = cfg.energise_ms;
            end else begin
                phase_next = PH_IDLE;
                timer_next = '0;
            end
        end else if (fire) begin
            case (phase_reg)
                PH_ENERGISE: begin
                    phase_next = PH_HOLD;
                    timer_next = '0;
                end
                PH_PULSE: begin
                    if (redo_reg < cfg.redo_count) begin
                        redo_next  = redo_reg + 8'd1;
                        phase_next = PH_GAP;
                        timer_next = cfg.redo_interval_ms;
                    end else begin
                        redo_next = '0;
                        if (en_on) begin
                            phase_next = PH_REST;
                            timer_next = TIMER_W'(REST_DELAY_MS);
                        end else begin
                            phase_next = PH_IDLE;
                            timer_next = '0;
                        end
                    end
                end
                PH_GAP: begin
                    phase_next = PH_PULSE;
                    timer_next = cfg.energise_ms;
                end
                PH_REST: begin
                    phase_next = PH_IDLE;
                    timer_next = '0;
                end
                default: ;
            endcase
        end else if (is_tick && active) begin
            timer_next = timer_reg - 16'd1;
        end
    end

    // pin levels
    always_comb begin
        duty_next   = duty_reg;
        brake_next  = brake_reg;
        enable_next = enable_reg;
        if (is_req) begin
            if (cfg.latching_mode) begin
                duty_next   = drive ? lvl_nbh : lvl_bh;
                brake_next  = drive ? cfg.brake_high : !cfg.brake_high;
                enable_next = en_on;
            end else if (drive) begin
                duty_next   = ener_mir;
                brake_next  = cfg.brake_high;
                enable_next = en_on;
            end else begin
                duty_next   = lvl_nbh;
                brake_next  = !cfg.brake_high;
                enable_next = 1'b0;
            end
        end else if (fire) begin
            case (phase_reg)
                PH_ENERGISE: duty_next = hold_mir;
                PH_PULSE: begin
                    duty_next  = lvl_bh;
                    brake_next = cfg.brake_high;
                end
                PH_GAP: begin
                    duty_next   = gap_drive ? lvl_nbh : lvl_bh;
                    brake_next  = gap_drive ? cfg.brake_high : !cfg.brake_high;
                    enable_next = en_on;
                end
                PH_REST: begin
                    duty_next   = lvl_nbh;
                    brake_next  = !cfg.brake_high;
                    enable_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            redo_reg      <= '0;
            req_reg       <= 1'b0;
            duty_reg      <= '0;
            brake_reg     <= 1'b0;
            enable_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            redo_reg      <= redo_next;
            req_reg       <= req_next;
            duty_reg      <= duty_next;
            brake_reg     <= brake_next;
            enable_reg    <= enable_next;
            out_valid_reg <= adv || (out_valid_reg && !out_ready);
        end
    end

    assign out_valid    = out_valid_reg;
    assign duty         = duty_reg;
    assign brake        = brake_reg;
    assign enable       = enable_reg;
    assign switch_state = req_reg;

endmodule

/* rtl/solenoid_drive_sequencer_core.sv */
// Solenoid hit-and-hold / latching sequencer.
// Result path: an accepted input beat passes the input register, then the
// state/result register, before its result beat is valid on the master port.
// One beat per cycle while m_tready is high; state update is combinational.
// Reset: aresetn synchronous active low; config to defaults, phase idle,
// pins and timers zero, no beats pending.
module solenoid_drive_sequencer_core
    import sds_pkg::*;
#(
    parameter int HAS_ENABLE    = 1,
    parameter int DUTY_BITS     = 10,
    parameter int REST_DELAY_MS = 1000
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] state_req
    input  logic [0:0]            s_tuser,   // [0] cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [9:0] drive_duty, [10] brake_pin,
                                             // [11] enable_pin, [12] switch_state
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int WIDE_W = DUTY_BITS + CFG_DUTY_W;

    cfg_t                 cfg;
    logic                 in_valid_reg;
    logic                 in_cmd_reg;
    logic                 in_req_reg;
    logic                 seq_ready;
    logic [DUTY_BITS-1:0] duty;
    logic [WIDE_W-1:0]    duty_wide;
    logic                 brake, enable, switch_state;

    sds_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign s_tready = !in_valid_reg || seq_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg <= s_tuser[0];
            in_req_reg <= s_tdata[0];
        end
    end

    sds_seq #(
        .HAS_ENABLE    (HAS_ENABLE),
        .DUTY_BITS     (DUTY_BITS),
        .REST_DELAY_MS (REST_DELAY_MS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .in_valid     (in_valid_reg),
        .in_cmd       (in_cmd_reg),
        .in_state_req (in_req_reg),
        .in_ready     (seq_ready),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .duty         (duty),
        .brake        (brake),
        .enable       (enable),
        .switch_state (switch_state)
    );

    assign duty_wide = {{CFG_DUTY_W{1'b0}}, duty};
    assign m_tdata   = {3'b000, switch_state, enable, brake, duty_wide[CFG_DUTY_W-1:0]};

endmodule
